// ===== hw/rtl/sxt_pkg.sv =====
// Shared types and constants of the S-expression tokenizer.
`default_nettype none

package sxt_pkg;

   // Lexer modes; codes 5 to 7 never arise and are handled as start.
   typedef enum logic [2:0] {
      MODE_START   = 3'd0,
      MODE_INTEGER = 3'd1,
      MODE_DECIMAL = 3'd2,
      MODE_STRING  = 3'd3,
      MODE_IDENT   = 3'd4
   } lex_mode_type;

   // Token kinds.
   localparam logic [2:0] KIND_EOF    = 3'd0;
   localparam logic [2:0] KIND_LPAREN = 3'd1;
   localparam logic [2:0] KIND_RPAREN = 3'd2;
   localparam logic [2:0] KIND_STRING = 3'd3;
   localparam logic [2:0] KIND_NUMBER = 3'd4;
   localparam logic [2:0] KIND_IDENT  = 3'd5;

   // Error codes.
   localparam logic [3:0] ERR_NONE        = 4'd0;
   localparam logic [3:0] ERR_BAD_START   = 4'd1;
   localparam logic [3:0] ERR_BAD_INTEGER = 4'd2;
   localparam logic [3:0] ERR_BAD_DECIMAL = 4'd3;
   localparam logic [3:0] ERR_BAD_IDENT   = 4'd4;
   localparam logic [3:0] ERR_EOF_INTEGER = 4'd5;
   localparam logic [3:0] ERR_EOF_DECIMAL = 4'd6;
   localparam logic [3:0] ERR_EOF_STRING  = 4'd7;
   localparam logic [3:0] ERR_EOF_IDENT   = 4'd8;

   // Result queue geometry.
   localparam int ResultDepth = 4;
   localparam int ResultPtrW  = $clog2(ResultDepth);
   localparam int ResultCntW  = $clog2(ResultDepth + 1);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_item_type;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       token_end;
      logic [3:0] error_code;
      logic       last;
   } rsp_item_type;

   // What one input item produces: zero, one or two result items.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } lex_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sxt_lexer.sv =====
// Combinational lexer step: next mode and result items for one character.
`default_nettype none

module sxt_lexer (
   input  sxt_pkg::lex_mode_type   mode,
   input  sxt_pkg::req_item_type   item,
   output sxt_pkg::lex_mode_type   next_mode,
   output sxt_pkg::lex_result_type result
);

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return (c == "(") || (c == ")") || is_space(c);
   endfunction

   function automatic sxt_pkg::rsp_item_type make_rsp(
      input logic [2:0] kind,
      input logic [7:0] data,
      input logic       valid,
      input logic       done,
      input logic [3:0] err
   );
      sxt_pkg::rsp_item_type r;
      r.token_kind = kind;
      r.data_byte  = valid ? data : 8'd0;
      r.byte_valid = valid;
      r.token_end  = done;
      r.error_code = err;
      r.last       = 1'b0;
      return r;
   endfunction

   // Mode reached by a character handled in start mode.
   function automatic sxt_pkg::lex_mode_type start_mode(
      input logic [7:0] c,
      input logic       eoi
   );
      sxt_pkg::lex_mode_type m;
      priority if (eoi) begin
         m = sxt_pkg::MODE_START;
      end else if (is_digit(c)) begin
         m = sxt_pkg::MODE_INTEGER;
      end else if ((c == "_") || is_alpha(c)) begin
         m = sxt_pkg::MODE_IDENT;
      end else if (c == "\"") begin
         m = sxt_pkg::MODE_STRING;
      end else begin
         m = sxt_pkg::MODE_START;
      end
      return m;
   endfunction

   // Whether a character handled in start mode produces a result item.
   function automatic logic start_has(input logic [7:0] c, input logic eoi);
      return eoi || !((c == "\"") || is_space(c));
   endfunction

   function automatic sxt_pkg::rsp_item_type start_rsp(
      input logic [7:0] c,
      input logic       eoi
   );
      sxt_pkg::rsp_item_type r;
      priority if (eoi) begin
         r = make_rsp(sxt_pkg::KIND_EOF, 8'd0, 1'b0, 1'b1, sxt_pkg::ERR_NONE);
      end else if (is_digit(c)) begin
         r = make_rsp(sxt_pkg::KIND_NUMBER, c, 1'b1, 1'b0, sxt_pkg::ERR_NONE);
      end else if ((c == "_") || is_alpha(c)) begin
         r = make_rsp(sxt_pkg::KIND_IDENT, c, 1'b1, 1'b0, sxt_pkg::ERR_NONE);
      end else if (c == "(") begin
         r = make_rsp(sxt_pkg::KIND_LPAREN, c, 1'b1, 1'b1, sxt_pkg::ERR_NONE);
      end else if (c == ")") begin
         r = make_rsp(sxt_pkg::KIND_RPAREN, c, 1'b1, 1'b1, sxt_pkg::ERR_NONE);
      end else begin
         r = make_rsp(sxt_pkg::KIND_EOF, 8'd0, 1'b0, 1'b0, sxt_pkg::ERR_BAD_START);
      end
      return r;
   endfunction

   logic [7:0] c;
   logic       eoi;
   logic       dec;

   assign c   = item.in_byte;
   assign eoi = item.end_of_input;
   assign dec = (mode == sxt_pkg::MODE_DECIMAL);

   // Next mode.
   always_comb begin
      unique case (mode)
         sxt_pkg::MODE_INTEGER, sxt_pkg::MODE_DECIMAL: begin
            priority if (eoi) begin
               next_mode = sxt_pkg::MODE_START;
            end else if (is_digit(c)) begin
               next_mode = mode;
            end else if (!dec && (c == ".")) begin
               next_mode = sxt_pkg::MODE_DECIMAL;
            end else if (is_delim(c)) begin
               next_mode = start_mode(c, 1'b0);
            end else begin
               next_mode = sxt_pkg::MODE_START;
            end
         end
         sxt_pkg::MODE_STRING: begin
            if (eoi || (c == "\"")) begin
               next_mode = sxt_pkg::MODE_START;
            end else begin
               next_mode = sxt_pkg::MODE_STRING;
            end
         end
         sxt_pkg::MODE_IDENT: begin
            priority if (eoi) begin
               next_mode = sxt_pkg::MODE_START;
            end else if (is_alpha(c) || is_digit(c)) begin
               next_mode = sxt_pkg::MODE_IDENT;
            end else if (is_delim(c)) begin
               next_mode = start_mode(c, 1'b0);
            end else begin
               next_mode = sxt_pkg::MODE_START;
            end
         end
         default: begin
            next_mode = start_mode(c, eoi);
         end
      endcase
   end

   // Result items.
   always_comb begin
      result = '0;
      unique case (mode)
         sxt_pkg::MODE_INTEGER, sxt_pkg::MODE_DECIMAL: begin
            priority if (eoi) begin
               result.count = 2'd1;
               result.first = make_rsp(sxt_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b0,
                  dec ? sxt_pkg::ERR_EOF_DECIMAL : sxt_pkg::ERR_EOF_INTEGER);
            end else if (is_digit(c) || (!dec && (c == "."))) begin
               result.count = 2'd1;
               result.first = make_rsp(sxt_pkg::KIND_NUMBER, c, 1'b1, 1'b0,
                  sxt_pkg::ERR_NONE);
            end else if (is_delim(c)) begin
               result.first = make_rsp(sxt_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b1,
                  sxt_pkg::ERR_NONE);
               result.second = start_rsp(c, 1'b0);
               result.count  = start_has(c, 1'b0) ? 2'd2 : 2'd1;
            end else begin
               result.count = 2'd1;
               result.first = make_rsp(sxt_pkg::KIND_NUMBER, 8'd0, 1'b0, 1'b0,
                  dec ? sxt_pkg::ERR_BAD_DECIMAL : sxt_pkg::ERR_BAD_INTEGER);
            end
         end
         sxt_pkg::MODE_STRING: begin
            result.count = 2'd1;
            priority if (eoi) begin
               result.first = make_rsp(sxt_pkg::KIND_STRING, 8'd0, 1'b0, 1'b0,
                  sxt_pkg::ERR_EOF_STRING);
            end else if (c == "\"") begin
               result.first = make_rsp(sxt_pkg::KIND_STRING, 8'd0, 1'b0, 1'b1,
                  sxt_pkg::ERR_NONE);
            end else begin
               result.first = make_rsp(sxt_pkg::KIND_STRING, c, 1'b1, 1'b0,
                  sxt_pkg::ERR_NONE);
            end
         end
         sxt_pkg::MODE_IDENT: begin
            priority if (eoi) begin
               result.count = 2'd1;
               result.first = make_rsp(sxt_pkg::KIND_IDENT, 8'd0, 1'b0, 1'b0,
                  sxt_pkg::ERR_EOF_IDENT);
            end else if (is_alpha(c) || is_digit(c)) begin
               result.count = 2'd1;
               result.first = make_rsp(sxt_pkg::KIND_IDENT, c, 1'b1, 1'b0,
                  sxt_pkg::ERR_NONE);
            end else if (is_delim(c)) begin
               result.first = make_rsp(sxt_pkg::KIND_IDENT, 8'd0, 1'b0, 1'b1,
                  sxt_pkg::ERR_NONE);
               result.second = start_rsp(c, 1'b0);
               result.count  = start_has(c, 1'b0) ? 2'd2 : 2'd1;
            end else begin
               result.count = 2'd1;
               result.first = make_rsp(sxt_pkg::KIND_IDENT, 8'd0, 1'b0, 1'b0,
                  sxt_pkg::ERR_BAD_IDENT);
            end
         end
         default: begin
            result.first = start_rsp(c, eoi);
            result.count = start_has(c, eoi) ? 2'd1 : 2'd0;
         end
      endcase
      // Mark the final result item of this character.
      if (result.count == 2'd2) begin
         result.second.last = 1'b1;
      end else begin
         result.first.last = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sexpr_tokenizer.sv =====
// Top level of the streaming S-expression tokenizer.
// Each accepted item is held in the input register and lexed combinationally; its result
// items are written into the result queue, from which they are offered one at a time.
// Throughput: one input item per cycle while the result queue has room for two result items.
// The lexer mode register closes the only loop, so each character is lexed combinationally.
// Synchronous active-high reset empties the input register and result queue, mode to start.
`default_nettype none

module sexpr_tokenizer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sxt_pkg::req_item_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sxt_pkg::rsp_item_type rsp_item
);

   localparam int Depth = sxt_pkg::ResultDepth;
   localparam int PtrW  = sxt_pkg::ResultPtrW;
   localparam int CntW  = sxt_pkg::ResultCntW;

   // Input register: holds one character until the lexer has taken it.
   logic                  in_valid_ff, in_valid_in;
   sxt_pkg::req_item_type in_item_ff;

   // Lexer mode, the only state carried from one character to the next.
   sxt_pkg::lex_mode_type mode_ff, mode_in;

   // Result queue. The lexer writes up to two items in a cycle, and the
   // output side takes one item per cycle unless the receiver stalls.
   sxt_pkg::rsp_item_type queue_ff [Depth];
   logic [PtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]       count_ff, count_in;

   sxt_pkg::lex_result_type lex_result;
   sxt_pkg::lex_mode_type   lex_next_mode;

   logic            room;
   logic            advance;
   logic            req_accept;
   logic            pop;
   logic [1:0]      push_n;

   sxt_lexer u_lexer (
      .mode      (mode_ff),
      .item      (in_item_ff),
      .next_mode (lex_next_mode),
      .result    (lex_result)
   );

   // The lexer consumes the held character only when the queue can take
   // the worst case of two result items, so nothing is ever dropped.
   assign room       = (count_ff <= CntW'(Depth - 2));
   assign advance    = in_valid_ff && room;
   assign req_stall  = in_valid_ff && !room;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign push_n    = advance ? lex_result.count : 2'd0;

   // Next values of the control registers.
   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      mode_in   = advance ? lex_next_mode : mode_ff;
      wr_ptr_in = wr_ptr_ff + PtrW'(push_n);
      rd_ptr_in = rd_ptr_ff + PtrW'(pop);
      count_in  = count_ff + CntW'(push_n) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= sxt_pkg::MODE_START;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // Payload registers carry no reset; their valid flags guard them.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= req_item;
      end
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= lex_result.first;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + PtrW'(1)] <= lex_result.second;
      end
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of the streaming S-expression tokenizer.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sxt_pkg::*;

   // Characters with a special meaning to the lexer.
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   // Generous bound on the length of the whole run.
   localparam int CycleLimit = 200000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // Predicted lexer state and the tokens still owed by the block, oldest first.
   lex_mode_type model_mode = MODE_START;
   rsp_item_type step_tokens[$];
   rsp_item_type expected_tokens[$];

   int unsigned items_sent = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;

   // Idling odds in percent, and the length of a deliberate receiver hold-off.
   int send_idle_pct = 36;
   int rsp_idle_pct = 36;
   int rsp_hold_left = 0;

   sexpr_tokenizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #2 clock = ~clock;

   // The run is cut off if it hangs; a hang is a failure in its own right.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver side. A hold-off requested by a test is counted down here one cycle
   // at a time; otherwise the receiver stalls at random at the current odds.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Lexer prediction. Character classes follow the plain C locale.
   // ---------------------------------------------------------------------------

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_delimiter(logic [7:0] c);
      return c == CH_LPAREN || c == CH_RPAREN || is_space(c);
   endfunction

   // Queue one token item of the current input; the data byte reads as zero
   // whenever it is not part of the token.
   task automatic add_token(input logic [2:0] kind, input logic [7:0] b, input logic bv,
                            input logic tend, input logic [3:0] err);
      rsp_item_type t;
      t.token_kind = kind;
      t.data_byte  = bv ? b : 8'd0;
      t.byte_valid = bv;
      t.token_end  = tend;
      t.error_code = err;
      t.last       = 1'b0;
      step_tokens.push_back(t);
   endtask

   // Any error drops the token being lexed and goes back to the start mode.
   task automatic lex_error(input logic [2:0] kind, input logic [3:0] err);
      model_mode = MODE_START;
      add_token(kind, 8'd0, 1'b0, 1'b0, err);
   endtask

   // A character seen in the start mode, either fresh or right after a
   // delimiter has closed a number or an identifier.
   task automatic lex_fresh_char(input logic [7:0] c, input logic eoi);
      model_mode = MODE_START;
      if (eoi) begin
         add_token(KIND_EOF, 8'd0, 1'b0, 1'b1, ERR_NONE);
      end else if (is_digit(c)) begin
         model_mode = MODE_INTEGER;
         add_token(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
      end else if (c == CH_UNDER || is_alpha(c)) begin
         model_mode = MODE_IDENT;
         add_token(KIND_IDENT, c, 1'b1, 1'b0, ERR_NONE);
      end else if (c == CH_LPAREN) begin
         add_token(KIND_LPAREN, c, 1'b1, 1'b1, ERR_NONE);
      end else if (c == CH_RPAREN) begin
         add_token(KIND_RPAREN, c, 1'b1, 1'b1, ERR_NONE);
      end else if (c == CH_QUOTE) begin
         model_mode = MODE_STRING;
      end else if (!is_space(c)) begin
         lex_error(KIND_EOF, ERR_BAD_START);
      end
   endtask

   // Works out the zero, one or two result items of one accepted input item and
   // appends them to the expected tokens, the final one flagged as last.
   task automatic predict_tokens(input req_item_type it);
      logic [7:0] c;
      logic       eoi;
      logic       dec;
      c = it.in_byte;
      eoi = it.end_of_input;
      dec = (model_mode == MODE_DECIMAL);
      step_tokens.delete();
      case (model_mode)
         MODE_INTEGER, MODE_DECIMAL: begin
            if (eoi) begin
               lex_error(KIND_NUMBER, dec ? ERR_EOF_DECIMAL : ERR_EOF_INTEGER);
            end else if (is_digit(c)) begin
               add_token(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
            end else if (!dec && c == CH_DOT) begin
               model_mode = MODE_DECIMAL;
               add_token(KIND_NUMBER, c, 1'b1, 1'b0, ERR_NONE);
            end else if (is_delimiter(c)) begin
               add_token(KIND_NUMBER, 8'd0, 1'b0, 1'b1, ERR_NONE);
               lex_fresh_char(c, 1'b0);
            end else begin
               lex_error(KIND_NUMBER, dec ? ERR_BAD_DECIMAL : ERR_BAD_INTEGER);
            end
         end
         MODE_STRING: begin
            if (eoi) begin
               lex_error(KIND_STRING, ERR_EOF_STRING);
            end else if (c == CH_QUOTE) begin
               model_mode = MODE_START;
               add_token(KIND_STRING, 8'd0, 1'b0, 1'b1, ERR_NONE);
            end else begin
               add_token(KIND_STRING, c, 1'b1, 1'b0, ERR_NONE);
            end
         end
         MODE_IDENT: begin
            if (eoi) begin
               lex_error(KIND_IDENT, ERR_EOF_IDENT);
            end else if (is_alpha(c) || is_digit(c)) begin
               add_token(KIND_IDENT, c, 1'b1, 1'b0, ERR_NONE);
            end else if (is_delimiter(c)) begin
               add_token(KIND_IDENT, 8'd0, 1'b0, 1'b1, ERR_NONE);
               lex_fresh_char(c, 1'b0);
            end else begin
               lex_error(KIND_IDENT, ERR_BAD_IDENT);
            end
         end
         default: begin
            lex_fresh_char(c, eoi);
         end
      endcase
      for (int i = 0; i < step_tokens.size(); i++) begin
         rsp_item_type t;
         t = step_tokens[i];
         t.last = (i == step_tokens.size() - 1);
         expected_tokens.push_back(t);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Checking. Both handshakes are sampled at the rising edge in this one
   // process, so the prediction for an item is always queued before any of its
   // results can be taken.
   // ---------------------------------------------------------------------------

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : token_checker
      rsp_item_type want;
      if (reset) begin
         model_mode = MODE_START;
      end else begin
         if (req_valid && !req_stall) begin
            predict_tokens(req_item);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               $error("result item %h arrived with nothing expected", rsp_item);
               fail_count++;
            end else begin
               want = expected_tokens.pop_front();
               compare_field("token_kind", want.token_kind, rsp_item.token_kind);
               compare_field("data_byte", want.data_byte, rsp_item.data_byte);
               compare_field("byte_valid", want.byte_valid, rsp_item.byte_valid);
               compare_field("token_end", want.token_end, rsp_item.token_end);
               compare_field("error_code", want.error_code, rsp_item.error_code);
               compare_field("last", want.last, rsp_item.last);
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sending. Every task here starts and ends at a falling edge, where the
   // inputs change; each falling edge sees at most one update of req_valid.
   // ---------------------------------------------------------------------------

   // Offers one item, after a random gap, and holds it until it is taken.
   task automatic send_char(input logic [7:0] b, input logic eoi);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item <= '{in_byte: b, end_of_input: eoi};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   // The byte that travels with an end-of-input mark is random, since it is ignored.
   task automatic send_eof();
      send_char(8'($urandom_range(255)), 1'b1);
   endtask

   // The sender pauses until every owed result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------
   // Random text. Most of it is well-formed tokens with random content; the rest
   // is stray bytes, end-of-input marks in mid-token and broken token endings.
   // ---------------------------------------------------------------------------

   function automatic logic [7:0] rand_delimiter();
      int pick;
      pick = $urandom_range(7);
      if (pick < 3) return " ";
      if (pick == 3) return CH_LPAREN;
      if (pick == 4) return CH_RPAREN;
      return 8'd9 + 8'($urandom_range(4));
   endfunction

   function automatic logic [7:0] rand_alnum();
      case ($urandom_range(2))
         0: return "0" + 8'($urandom_range(9));
         1: return "A" + 8'($urandom_range(25));
         default: return "a" + 8'($urandom_range(25));
      endcase
   endfunction

   // What follows a number or an identifier: usually a delimiter, sometimes an
   // end-of-input mark or any byte at all, which is mostly an error.
   task automatic send_token_end();
      int pick;
      pick = $urandom_range(99);
      if (pick < 84) send_char(rand_delimiter(), 1'b0);
      else if (pick < 92) send_eof();
      else send_char(8'($urandom_range(255)), 1'b0);
   endtask

   task automatic send_number();
      send_char("0" + 8'($urandom_range(9)), 1'b0);
      repeat ($urandom_range(5)) send_char("0" + 8'($urandom_range(9)), 1'b0);
      if ($urandom_range(1)) begin
         send_char(CH_DOT, 1'b0);
         repeat ($urandom_range(4)) send_char("0" + 8'($urandom_range(9)), 1'b0);
      end
      send_token_end();
   endtask

   task automatic send_identifier();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) send_char(CH_UNDER, 1'b0);
      else if (pick < 5) send_char("A" + 8'($urandom_range(25)), 1'b0);
      else send_char("a" + 8'($urandom_range(25)), 1'b0);
      repeat ($urandom_range(6)) send_char(rand_alnum(), 1'b0);
      send_token_end();
   endtask

   // String contents may be any byte but the quote, control bytes included.
   task automatic send_string();
      logic [7:0] c;
      send_char(CH_QUOTE, 1'b0);
      repeat ($urandom_range(8)) begin
         do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
         send_char(c, 1'b0);
      end
      if ($urandom_range(9) == 0) send_eof();
      else send_char(CH_QUOTE, 1'b0);
   endtask

   task automatic send_random_token();
      int pick;
      pick = $urandom_range(99);
      if (pick < 14) send_char(CH_LPAREN, 1'b0);
      else if (pick < 28) send_char(CH_RPAREN, 1'b0);
      else if (pick < 48) send_number();
      else if (pick < 66) send_identifier();
      else if (pick < 78) send_string();
      else if (pick < 84) send_char(rand_delimiter(), 1'b0);
      else if (pick < 87) send_eof();
      else send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Start mode: the lowest and highest bytes are bad start characters, the
   // parentheses are one-byte tokens, white space is dropped, and an
   // end-of-input mark gives an eof token whatever byte comes with it.
   task automatic test_start_chars();
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_text("()\t");
      send_char(8'hFF, 1'b1);
      wait_for_results();
   endtask

   // Numbers: a decimal closed by a parenthesis, which then opens a list (two
   // results from one item); a second dot; a letter inside an integer; and an
   // end-of-input mark inside an integer.
   task automatic test_numbers();
      send_text("9.0(");
      send_text("1..");
      send_text("3a");
      send_text("5");
      send_eof();
      wait_for_results();
   endtask

   // Strings: the top byte is plain string data, the quotes never show as data bytes,
   // and an end-of-input mark inside a string is an error.
   task automatic test_strings();
      send_char(CH_QUOTE, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(CH_QUOTE, 1'b0);
      send_char(CH_QUOTE, 1'b0);
      send_eof();
      wait_for_results();
   endtask

   // Identifiers: a leading underscore is fine and a closing parenthesis ends
   // the name, an underscore later on is an error, and so is an end-of-input
   // mark inside a name.
   task automatic test_identifiers();
      send_text("_a)");
      send_text("b_");
      send_text("c");
      send_eof();
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // items with no gaps, so the result queue fills and the input stalls.
   task automatic test_backpressure();
      int unsigned first;
      first = items_sent;
      send_idle_pct = 0;
      @(posedge clock);
      rsp_hold_left = 150;
      @(negedge clock);
      while (items_sent < first + 40) send_random_token();
      send_idle_pct = 36;
      wait_for_results();
   endtask

   // Random token stream; a stretch in the middle runs with no idling on
   // either side.
   task automatic test_random_text();
      int unsigned first;
      first = items_sent;
      while (items_sent < first + 650) begin
         if (items_sent >= first + 250 && items_sent < first + 400) begin
            send_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            send_idle_pct = 36;
            rsp_idle_pct = 36;
         end
         send_random_token();
      end
      send_idle_pct = 36;
      rsp_idle_pct = 36;
      wait_for_results();
   endtask

   initial begin : run_tests
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_start_chars();
      test_numbers();
      test_strings();
      test_identifiers();
      test_backpressure();
      test_random_text();

      // Keep the clock running after the last test so that a stray extra result would still be caught.
      repeat (8) @(posedge clock);
      if (expected_tokens.size() != 0) begin
         $error("%0d expected result items never arrived", expected_tokens.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/sxt_pkg.sv
hw/rtl/sxt_lexer.sv
hw/rtl/sexpr_tokenizer.sv
tb/testbench.sv
